[rtl/pab_pkg.sv]
// Shared constants, the control struct and saturation helper for the polygon area block.
package pab_pkg;

  localparam int AREA_W = 42;
  localparam int SUM_W  = 43;
  localparam int DIFF_W = 45;
  localparam int ACC_W  = 46;

  localparam logic signed [ACC_W-1:0] SUM_MAX_A = ACC_W'(64'sd4398046511103);
  localparam logic signed [ACC_W-1:0] SUM_MIN_A = -SUM_MAX_A - ACC_W'(1);

  typedef struct packed {
    logic first;
    logic last;
    logic ovf;
  } pab_ctl_t;

  // Clamp a widened running sum back into the signed range of the accumulator.
  function automatic logic signed [SUM_W-1:0] pab_sat_sum(input logic signed [ACC_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    if (v > SUM_MAX_A) begin
      r = SUM_MAX_A[SUM_W-1:0];
    end else if (v < SUM_MIN_A) begin
      r = SUM_MIN_A[SUM_W-1:0];
    end else begin
      r = v[SUM_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/pab_in_if.sv]
// Vertex channel: valid/ready handshake with one vertex per beat.
interface pab_in_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex_x;
  logic signed [COORD_WIDTH-1:0] vertex_y;
  logic                          last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                  input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                  output ready);
endinterface

[rtl/pab_out_if.sv]
// Result channel: valid/ready handshake with one polygon summary per beat.
interface pab_out_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic [41:0]                   area_twice;
  logic signed [COORD_WIDTH:0]   center_x_twice;
  logic signed [COORD_WIDTH:0]   center_y_twice;
  logic [COORD_WIDTH-1:0]        box_width;
  logic [COORD_WIDTH-1:0]        box_height;
  logic                          too_many_vertices;

  modport source (output valid, output area_twice, output center_x_twice,
                  output center_y_twice, output box_width, output box_height,
                  output too_many_vertices, input ready);
  modport sink   (input valid, input area_twice, input center_x_twice,
                  input center_y_twice, input box_width, input box_height,
                  input too_many_vertices, output ready);
endinterface

[rtl/pab_front.sv]
// Front end: takes vertex beats, tracks polygon state and classifies each vertex.
module pab_front #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_WIDTH  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  pab_in_if.sink                       in_ch,
  input  logic                         q_full,
  output logic                         q_push,
  output pab_pkg::pab_ctl_t            ctl_o,
  output logic [10*COORD_WIDTH-1:0]    coord_o
);
  import pab_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int CNT_W = $clog2(MAX_VERTICES + 2);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERTICES);

  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 ovf_r, ovf_nxt;
  logic signed [CW-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic signed [CW-1:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic signed [CW-1:0] fx, fy, mnx, mxx, mny, mxy;
  logic signed [CW-1:0] vx, vy;
  logic                 is_first, accept;

  assign vx       = in_ch.vertex_x;
  assign vy       = in_ch.vertex_y;
  assign in_ch.ready = !q_full;
  assign accept   = in_ch.valid && !q_full;
  assign q_push   = accept;
  assign is_first = (cnt_r == '0);

  always_comb begin
    fx  = is_first ? vx : first_x_r;
    fy  = is_first ? vy : first_y_r;
    mnx = (is_first || vx < min_x_r) ? vx : min_x_r;
    mxx = (is_first || vx > max_x_r) ? vx : max_x_r;
    mny = (is_first || vy < min_y_r) ? vy : min_y_r;
    mxy = (is_first || vy > max_y_r) ? vy : max_y_r;
    ovf_nxt = ovf_r || (cnt_r >= MAX_CNT);
    cnt_nxt = (cnt_r <= MAX_CNT) ? cnt_r + CNT_W'(1) : cnt_r;
  end

  assign ctl_o   = '{first: is_first, last: in_ch.last_vertex, ovf: ovf_nxt};
  assign coord_o = {vx, vy, prev_x_r, prev_y_r, fx, fy, mnx, mxx, mny, mxy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (accept) begin
      // A closing vertex returns the polygon tracker to its empty state.
      cnt_r <= in_ch.last_vertex ? '0 : cnt_nxt;
      ovf_r <= in_ch.last_vertex ? 1'b0 : ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first_x_r <= fx;
      first_y_r <= fy;
      prev_x_r  <= vx;
      prev_y_r  <= vy;
      min_x_r   <= mnx;
      max_x_r   <= mxx;
      min_y_r   <= mny;
      max_y_r   <= mxy;
    end
  end

endmodule

[rtl/pab_fifo.sv]
// Small flop-based queue between the vertex front end and the arithmetic back end.
module pab_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);
  import pab_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == DEPTH_C);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_P) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_P) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[rtl/pab_back.sv]
// Back end: cross products, shoelace accumulation, box geometry and the result register.
module pab_back #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  pab_pkg::pab_ctl_t            ctl_i,
  input  logic [10*COORD_WIDTH-1:0]    coord_i,
  pab_out_if.source                    out_ch
);
  import pab_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int PW = 2 * CW;
  localparam int DW = (PW + 1 > DIFF_W) ? PW + 1 : DIFF_W;
  localparam logic signed [DW-1:0] LIM_P = {{(DW-44){1'b0}}, 1'b1, 43'b0};
  localparam logic signed [DW-1:0] LIM_N = -LIM_P;
  localparam logic [AREA_W-1:0] AREA_CAP = '1;

  // Difference of two products, clamped to plus or minus 2^43.
  function automatic logic signed [DIFF_W-1:0] diff_clamp(input logic signed [PW-1:0] a,
                                                          input logic signed [PW-1:0] b);
    logic signed [DW-1:0] d;
    d = DW'(a) - DW'(b);
    if (d > LIM_P) begin
      d = LIM_P;
    end else if (d < LIM_N) begin
      d = LIM_N;
    end
    return d[DIFF_W-1:0];
  endfunction

  logic adv;
  logic signed [CW-1:0] vx, vy, px, py, fx, fy, mnx, mxx, mny, mxy;

  // Stage 1: products.
  logic                 s1_v_r;
  pab_ctl_t             s1_ctl_r;
  logic signed [PW-1:0] p1_r, p2_r, p3_r, p4_r;
  logic signed [CW-1:0] s1_mnx_r, s1_mxx_r, s1_mny_r, s1_mxy_r;
  // Stage 2: differences and box geometry.
  logic                     s2_v_r;
  pab_ctl_t                 s2_ctl_r;
  logic signed [DIFF_W-1:0] d1_r, d2_r;
  logic signed [CW:0]       s2_cx_r, s2_cy_r;
  logic [CW-1:0]            s2_bw_r, s2_bh_r;
  // Stage 3: running sum.
  logic                     s3_v_r;
  pab_ctl_t                 s3_ctl_r;
  logic signed [SUM_W-1:0]  cross_sum_r, cross_sum_nxt;
  logic signed [DIFF_W-1:0] s3_d2_r;
  logic signed [CW:0]       s3_cx_r, s3_cy_r;
  logic [CW-1:0]            s3_bw_r, s3_bh_r;
  // Stage 4: closing term.
  logic                     s4_v_r;
  pab_ctl_t                 s4_ctl_r;
  logic signed [SUM_W-1:0]  s4_sum_r, s4_sum_nxt;
  logic signed [CW:0]       s4_cx_r, s4_cy_r;
  logic [CW-1:0]            s4_bw_r, s4_bh_r;
  // Result register.
  logic                     out_v_r;
  logic [AREA_W-1:0]        area_r;
  logic [SUM_W-1:0]         mag;
  logic signed [CW:0]       out_cx_r, out_cy_r;
  logic [CW-1:0]            out_bw_r, out_bh_r;
  logic                     out_ovf_r;

  assign adv   = !out_v_r || out_ch.ready;
  assign q_pop = adv && !q_empty;

  assign vx  = coord_i[10*CW-1 -: CW];
  assign vy  = coord_i[9*CW-1  -: CW];
  assign px  = coord_i[8*CW-1  -: CW];
  assign py  = coord_i[7*CW-1  -: CW];
  assign fx  = coord_i[6*CW-1  -: CW];
  assign fy  = coord_i[5*CW-1  -: CW];
  assign mnx = coord_i[4*CW-1  -: CW];
  assign mxx = coord_i[3*CW-1  -: CW];
  assign mny = coord_i[2*CW-1  -: CW];
  assign mxy = coord_i[CW-1    -: CW];

  always_comb begin
    cross_sum_nxt = s2_ctl_r.first ? '0
                  : pab_sat_sum({{(ACC_W-SUM_W){cross_sum_r[SUM_W-1]}}, cross_sum_r}
                                + {{(ACC_W-DIFF_W){d1_r[DIFF_W-1]}}, d1_r});
    s4_sum_nxt    = pab_sat_sum({{(ACC_W-SUM_W){cross_sum_r[SUM_W-1]}}, cross_sum_r}
                                + {{(ACC_W-DIFF_W){s3_d2_r[DIFF_W-1]}}, s3_d2_r});
    mag = s4_sum_r[SUM_W-1] ? SUM_W'(~s4_sum_r + SUM_W'(1)) : SUM_W'(s4_sum_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      cross_sum_r <= '0;
    end else if (adv) begin
      s1_v_r  <= !q_empty;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      out_v_r <= s4_v_r && s4_ctl_r.last;
      if (s2_v_r) begin
        cross_sum_r <= cross_sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctl_r <= ctl_i;
      p1_r     <= px * vy;
      p2_r     <= vx * py;
      p3_r     <= vx * fy;
      p4_r     <= fx * vy;
      s1_mnx_r <= mnx;
      s1_mxx_r <= mxx;
      s1_mny_r <= mny;
      s1_mxy_r <= mxy;

      s2_ctl_r <= s1_ctl_r;
      d1_r     <= diff_clamp(p1_r, p2_r);
      d2_r     <= diff_clamp(p3_r, p4_r);
      s2_cx_r  <= {s1_mnx_r[CW-1], s1_mnx_r} + {s1_mxx_r[CW-1], s1_mxx_r};
      s2_cy_r  <= {s1_mny_r[CW-1], s1_mny_r} + {s1_mxy_r[CW-1], s1_mxy_r};
      s2_bw_r  <= CW'(s1_mxx_r - s1_mnx_r);
      s2_bh_r  <= CW'(s1_mxy_r - s1_mny_r);

      s3_ctl_r <= s2_ctl_r;
      s3_d2_r  <= d2_r;
      s3_cx_r  <= s2_cx_r;
      s3_cy_r  <= s2_cy_r;
      s3_bw_r  <= s2_bw_r;
      s3_bh_r  <= s2_bh_r;

      s4_ctl_r <= s3_ctl_r;
      s4_sum_r <= s4_sum_nxt;
      s4_cx_r  <= s3_cx_r;
      s4_cy_r  <= s3_cy_r;
      s4_bw_r  <= s3_bw_r;
      s4_bh_r  <= s3_bh_r;

      area_r    <= mag[SUM_W-1] ? AREA_CAP : mag[AREA_W-1:0];
      out_cx_r  <= s4_cx_r;
      out_cy_r  <= s4_cy_r;
      out_bw_r  <= s4_bw_r;
      out_bh_r  <= s4_bh_r;
      out_ovf_r <= s4_ctl_r.ovf;
    end
  end

  assign out_ch.valid             = out_v_r;
  assign out_ch.area_twice        = area_r;
  assign out_ch.center_x_twice    = out_cx_r;
  assign out_ch.center_y_twice    = out_cy_r;
  assign out_ch.box_width         = out_bw_r;
  assign out_ch.box_height        = out_bh_r;
  assign out_ch.too_many_vertices = out_ovf_r;

endmodule

[rtl/polygon_area_and_bounding_box.sv]
// Top level: streaming shoelace polygon area and bounding box.
//
// Vertices arrive on in_ch, one signed (x, y) pair per beat, with last_vertex
// set on the beat that closes the polygon. For each closed polygon one beat
// leaves on out_ch carrying twice the absolute area, twice the box centre,
// the box width and height, and a flag set when the polygon had more than
// MAX_VERTICES vertices. Vertices that do not close a polygon give no beat.
// The block takes one vertex per cycle for as long as results are taken.
// The result for a polygon passes through the queue and then four stages of
// products, differences, running sum and closing term, before the result
// register.
// The single running-sum register is the loop that sets the rate of one
// vertex per cycle; each vertex costs four narrow multiplications in parallel.
// When a result beat is waiting and the receiver holds ready low, the whole
// back end freezes and the four-entry queue goes on taking vertices until it
// fills, after which in_ch.ready falls. Synchronous reset empties the queue
// and the pipeline and starts a fresh polygon; no output beat is pending
// after reset.
module polygon_area_and_bounding_box #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_WIDTH  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  pab_in_if.sink    in_ch,
  pab_out_if.source out_ch
);
  import pab_pkg::*;

  localparam int COORD_BITS = 10 * COORD_WIDTH;
  localparam int ENT_W      = COORD_BITS + $bits(pab_ctl_t);

  // Queue entry: the vertex, its predecessor, the polygon's first vertex and
  // the bounding box as it stands after this vertex, plus the control flags.
  pab_ctl_t              f_ctl, b_ctl;
  logic [COORD_BITS-1:0] f_coord, b_coord;
  logic [ENT_W-1:0]      q_rdata;
  logic                  q_push, q_pop, q_full, q_empty;

  pab_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .ctl_o   (f_ctl),
    .coord_o (f_coord)
  );

  pab_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (4)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({f_coord, f_ctl}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign b_coord = q_rdata[ENT_W-1 -: COORD_BITS];
  assign b_ctl   = q_rdata[$bits(pab_ctl_t)-1:0];

  pab_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .ctl_i   (b_ctl),
    .coord_i (b_coord),
    .out_ch  (out_ch)
  );

endmodule
